// ===== rtl/ccnb_pkg.sv =====
// ----------------------------------------------------------------------------
// ccnb_pkg
// Shared constants, status codes and the result beat type of the CCNb
// element walker.
// ----------------------------------------------------------------------------
package ccnb_pkg;

  localparam int MAX_DEPTH         = 32;
  localparam int MAX_ELEMENT_BYTES = 65536;
  localparam int MAX_HEADER_BYTES  = 4;

  localparam int HN_W    = 25;                       // header number / length
  localparam int ACC_W   = HN_W - 4;                 // bits held before terminal byte
  localparam int HB_W    = $clog2(MAX_HEADER_BYTES);
  localparam int DEPTH_W = 6;
  localparam int OFS_W   = 16;
  localparam int POS_W   = $clog2(MAX_ELEMENT_BYTES + 1);

  localparam logic [2:0] TYPE_DTAG  = 3'd2;
  localparam logic [2:0] TYPE_DATTR = 3'd4;
  localparam logic [2:0] TYPE_BLOB  = 3'd5;
  localparam logic [2:0] TYPE_UDATA = 3'd6;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_DONE  = 3'd1,
    ST_BAD   = 3'd2,
    ST_TRUNC = 3'd3,
    ST_LIMIT = 3'd4
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 header_complete;
    logic [HN_W-1:0]      header_number;
    logic [2:0]           header_type;
    logic [DEPTH_W-1:0]   nest_level;
    logic                 value_found;
    logic [OFS_W-1:0]     value_offset;
    logic [HN_W-1:0]      value_length;
  } result_t;

endpackage

// ===== rtl/ccnb_out_skid.sv =====
// ----------------------------------------------------------------------------
// ccnb_out_skid
// Two-entry output buffer: a main register that drives the result channel
// and a skid register that catches one beat while the consumer stalls.
// ----------------------------------------------------------------------------
module ccnb_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ccnb_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output ccnb_pkg::result_t out_data
);
  import ccnb_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // skid only fills behind a held main beat
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry without main entry");

  // a stalled beat with a waiting skid entry keeps the skid entry
  a_skid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_r)))
    else $error("skid entry lost during stall");

endmodule

// ===== rtl/ccnb_element_walker_top.sv =====
// ----------------------------------------------------------------------------
// ccnb_element_walker_top
// Walks one CCNb binary-XML element a byte at a time and reports per byte.
// ----------------------------------------------------------------------------
// Each input beat carries one buffer byte and yields exactly one result beat.
// The block takes one byte per clock while the skid entry is empty; the result
// is registered into the output buffer on acceptance. The per-byte state
// update (header accumulate, payload skip count, nesting depth) is a single
// registered step, and a two-entry output buffer lets input continue for one
// beat while the result channel stalls. After any status other than
// in-progress, the walker returns to its reset state and the next byte starts
// a new element.
module ccnb_element_walker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_header_complete,
  output logic [24:0] out_header_number,
  output logic [2:0]  out_header_type,
  output logic [5:0]  out_nest_level,
  output logic        out_value_found,
  output logic [15:0] out_value_offset,
  output logic [24:0] out_value_length
);
  import ccnb_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_INSIDE = 2'd1,
    MODE_SKIP   = 2'd2
  } mode_t;

  mode_t              mode_r,   mode_nxt;
  logic [ACC_W-1:0]   accum_r,  accum_nxt;
  logic [HB_W-1:0]    hbytes_r, hbytes_nxt;
  logic [HN_W-1:0]    skip_r,   skip_nxt;
  logic [DEPTH_W-1:0] depth_r,  depth_nxt;
  logic [POS_W-1:0]   pos_r,    pos_nxt;
  logic [OFS_W-1:0]   vstart_r, vstart_nxt;
  logic [HN_W-1:0]    vsize_r,  vsize_nxt;
  logic               vseen_r,  vseen_nxt;

  status_t            status;
  logic               hc;
  logic [HN_W-1:0]    hn;
  logic [2:0]         ht;
  logic               accept;
  result_t            res;
  logic               can_push;
  result_t            out_data;

  assign accept   = in_valid && in_ready;
  assign in_ready = can_push;

  always_comb begin
    mode_nxt   = mode_r;
    accum_nxt  = accum_r;
    hbytes_nxt = hbytes_r;
    skip_nxt   = skip_r;
    depth_nxt  = depth_r;
    pos_nxt    = pos_r;
    vstart_nxt = vstart_r;
    vsize_nxt  = vsize_r;
    vseen_nxt  = vseen_r;
    status     = ST_BUSY;
    hc         = 1'b0;
    hn         = '0;
    ht         = 3'd0;

    if (pos_r >= POS_W'(MAX_ELEMENT_BYTES)) begin
      status = ST_LIMIT;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      if (mode_r == MODE_SKIP) begin
        if (skip_r != '0) skip_nxt = skip_r - HN_W'(1);
        if (skip_nxt == '0) begin
          if (depth_r == '0) status = ST_DONE;
          else mode_nxt = MODE_INSIDE;
        end
      end else if (hbytes_r == '0 && in_data_byte == 8'd0) begin
        // end marker closes one level
        hc = 1'b1;
        if (mode_r == MODE_IDLE || depth_r == '0) begin
          status = ST_BAD;
        end else begin
          depth_nxt = depth_r - DEPTH_W'(1);
          if (depth_nxt == '0) status = ST_DONE;
        end
      end else if (in_data_byte[7]) begin
        hn         = {accum_r, in_data_byte[6:3]};
        ht         = in_data_byte[2:0];
        hc         = 1'b1;
        accum_nxt  = '0;
        hbytes_nxt = '0;
        if (ht inside {TYPE_BLOB, TYPE_UDATA}) begin
          vseen_nxt  = 1'b1;
          vstart_nxt = pos_nxt[OFS_W-1:0];
          vsize_nxt  = hn;
          if (hn == '0) begin
            if (depth_r == '0) status = ST_DONE;
            else mode_nxt = MODE_INSIDE;
          end else begin
            skip_nxt = hn;
            mode_nxt = MODE_SKIP;
          end
        end else if (ht inside {TYPE_DTAG, TYPE_DATTR}) begin
          if (depth_r >= DEPTH_W'(MAX_DEPTH)) begin
            status = ST_LIMIT;
          end else begin
            depth_nxt = depth_r + DEPTH_W'(1);
            mode_nxt  = MODE_INSIDE;
          end
        end else begin
          status = ST_BAD;
        end
      end else begin
        if ((HB_W+1)'(hbytes_r) + (HB_W+1)'(1) >= (HB_W+1)'(MAX_HEADER_BYTES)) begin
          status = ST_BAD;
        end else begin
          accum_nxt  = {accum_r[ACC_W-8:0], in_data_byte[6:0]};
          hbytes_nxt = hbytes_r + HB_W'(1);
        end
      end
    end

    if (status == ST_BUSY && in_last_byte) status = ST_TRUNC;

    res.status          = status;
    res.header_complete = hc;
    res.header_number   = hn;
    res.header_type     = ht;
    res.nest_level      = depth_nxt;
    res.value_found     = vseen_nxt;
    res.value_offset    = vstart_nxt;
    res.value_length    = vsize_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && status != ST_BUSY)) begin
      mode_r   <= MODE_IDLE;
      accum_r  <= '0;
      hbytes_r <= '0;
      skip_r   <= '0;
      depth_r  <= '0;
      pos_r    <= '0;
      vstart_r <= '0;
      vsize_r  <= '0;
      vseen_r  <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      accum_r  <= accum_nxt;
      hbytes_r <= hbytes_nxt;
      skip_r   <= skip_nxt;
      depth_r  <= depth_nxt;
      pos_r    <= pos_nxt;
      vstart_r <= vstart_nxt;
      vsize_r  <= vsize_nxt;
      vseen_r  <= vseen_nxt;
    end
  end

  ccnb_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status          = out_data.status;
  assign out_header_complete = out_data.header_complete;
  assign out_header_number   = out_data.header_number;
  assign out_header_type     = out_data.header_type;
  assign out_nest_level      = out_data.nest_level;
  assign out_value_found     = out_data.value_found;
  assign out_value_offset    = out_data.value_offset;
  assign out_value_length    = out_data.value_length;

  // a payload skip always has bytes left to consume
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SKIP) |-> (skip_r != '0))
    else $error("skip mode with zero count");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth above limit");

  // idle walker holds no open level and no skip count
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (depth_r == '0 && skip_r == '0))
    else $error("idle mode with leftover state");

endmodule
